@@ sv/cbm_pkg.sv @@
// shared types, codes and defaults for the circular boundary morphology block
`default_nettype none
package cbm_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_RADIUS_DEF = 7;

  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [10:0] HEIGHT_RST = 11'd480;
  localparam logic [6:0]  RADIUS_RST = 7'd16;
  localparam logic        MODE_RST   = 1'b0;

  // radius of 1.0 in q4.4
  localparam logic [7:0]  RADIUS_ONE = 8'd16;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_RADIUS = 2'd2;
  localparam logic [1:0] CFG_MODE   = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORED,
    ST_OFF,
    ST_ISSUE,
    ST_CHK,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    ADR_LOAD,
    ADR_READ,
    ADR_CAND
  } adr_t;

  // center and the four neighbors of a candidate boundary pixel
  typedef enum logic [2:0] {
    NB_C,
    NB_L,
    NB_R,
    NB_U,
    NB_D
  } nb_t;

  typedef struct packed {
    logic load;
    logic emit_blank;
    logic emit;
    logic fill;
    logic setup;
    logic latch_cand;
    logic next_off;
    adr_t addr_sel;
    nb_t  nb;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic pass;
    logic off_ok;
    logic off_last;
    logic rd_zero;
  } sts_t;

  function automatic nb_t nb_succ(input nb_t k);
    nb_t n;
    unique case (k)
      NB_C:    n = NB_L;
      NB_L:    n = NB_R;
      NB_R:    n = NB_U;
      NB_U:    n = NB_D;
      default: n = NB_D;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ sv/cbm_ram.sv @@
// generic single-port ram with registered read
`default_nettype none
module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

@@ sv/cbm_dp.sv @@
// datapath: config registers, frame counters, kernel offsets, frame store and result register
`default_nettype none
module cbm_dp #(
  parameter int MAX_WIDTH  = cbm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cbm_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = cbm_pkg::MAX_RADIUS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    pixel_value,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [10:0]   cfg_data,
  input  wire cbm_pkg::cmd_t cmd,
  output cbm_pkg::sts_t      sts,
  output logic               strobe,
  output logic [7:0]         out_pixel,
  output logic               ready_res,
  output logic               last
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int AW  = XW + YW;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int WE  = (WW > 11) ? WW : 11;
  localparam int HE  = (HW > 11) ? HW : 11;
  localparam int CXW = WW + 2;
  localparam int CYW = HW + 2;
  localparam logic [7:0] RMAX = 8'(MAX_RADIUS * 16 + 15);

  logic [10:0] cfg_width;
  logic [10:0] cfg_height;
  logic [6:0]  cfg_radius;
  logic        cfg_mode;
  logic        cfg_geom;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= cbm_pkg::WIDTH_RST;
      cfg_height <= cbm_pkg::HEIGHT_RST;
      cfg_radius <= cbm_pkg::RADIUS_RST;
      cfg_mode   <= cbm_pkg::MODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbm_pkg::CFG_WIDTH:  cfg_width  <= cfg_data;
        cbm_pkg::CFG_HEIGHT: cfg_height <= cfg_data;
        cbm_pkg::CFG_RADIUS: cfg_radius <= cfg_data[6:0];
        cbm_pkg::CFG_MODE:   cfg_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_geom = cfg_we &&
    (cfg_index == cbm_pkg::CFG_WIDTH || cfg_index == cbm_pkg::CFG_HEIGHT);

  // saturated geometry
  logic [WE-1:0] w_raw;
  logic [HE-1:0] h_raw;
  logic [WW-1:0] weff;
  logic [HW-1:0] heff;

  assign w_raw = WE'(cfg_width);
  assign h_raw = HE'(cfg_height);

  always_comb begin
    if (w_raw == '0) weff = WW'(1);
    else if (w_raw > WE'(MAX_WIDTH)) weff = WW'(MAX_WIDTH);
    else weff = WW'(w_raw);
    if (h_raw == '0) heff = HW'(1);
    else if (h_raw > HE'(MAX_HEIGHT)) heff = HW'(MAX_HEIGHT);
    else heff = HW'(h_raw);
  end

  // load and read positions
  logic [XW-1:0] lx, rx, bx;
  logic [YW-1:0] ly, ry, by;
  logic          full;
  logic          bx_last, by_last, rx_last, ry_last;

  assign bx      = full ? '0 : lx;
  assign by      = full ? '0 : ly;
  assign bx_last = (WW'(bx) == weff - WW'(1));
  assign by_last = (HW'(by) == heff - HW'(1));
  assign rx_last = (WW'(rx) == weff - WW'(1));
  assign ry_last = (HW'(ry) == heff - HW'(1));

  always_ff @(posedge clk) begin
    if (rst || cfg_geom) begin
      lx   <= '0;
      ly   <= '0;
      rx   <= '0;
      ry   <= '0;
      full <= 1'b0;
    end else if (cmd.load) begin
      rx <= '0;
      ry <= '0;
      if (bx_last && by_last) begin
        lx   <= '0;
        ly   <= '0;
        full <= 1'b1;
      end else if (bx_last) begin
        lx   <= '0;
        ly   <= by + YW'(1);
        full <= 1'b0;
      end else begin
        lx   <= bx + XW'(1);
        ly   <= by;
        full <= 1'b0;
      end
    end else if (cmd.emit) begin
      if (rx_last) begin
        rx <= '0;
        ry <= ry_last ? '0 : ry + YW'(1);
      end else begin
        rx <= rx + XW'(1);
      end
    end
  end

  // kernel geometry
  logic [7:0]  rc;
  logic [3:0]  h_c;
  logic [4:0]  twoh1;
  logic [3:0]  hr;
  logic [15:0] rr;
  logic [7:0]  stored;
  logic [7:0]  rdata;

  assign rc    = (8'(cfg_radius) > RMAX) ? RMAX : 8'(cfg_radius);
  assign h_c   = rc[7:4];
  assign twoh1 = {h_c, 1'b1};

  logic signed [4:0] dx, dy, hs_r, hs_c;
  assign hs_c = $signed({1'b0, h_c});
  assign hs_r = $signed({1'b0, hr});

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      stored <= rdata;
      rr     <= 16'(rc) * 16'(rc);
      hr     <= h_c;
      dx     <= -hs_c;
      dy     <= -hs_c;
    end else if (cmd.next_off) begin
      if (dx == hs_r) begin
        dx <= -hs_r;
        dy <= dy + 5'sd1;
      end else begin
        dx <= dx + 5'sd1;
      end
    end
  end

  // offset test: inside the circle and candidate in the interior
  logic [4:0]  dxa, dya;
  logic [8:0]  sq;
  logic        in_circle;
  logic signed [CXW-1:0] cx, hx, wlim;
  logic signed [CYW-1:0] cy, hy, hlim;
  logic        int_ok;

  assign dxa       = dx[4] ? 5'(-dx) : dx;
  assign dya       = dy[4] ? 5'(-dy) : dy;
  assign sq        = 9'(dxa[3:0]) * 9'(dxa[3:0]) + 9'(dya[3:0]) * 9'(dya[3:0]);
  assign in_circle = ({sq, 8'b0} <= 17'(rr));

  assign cx   = $signed(CXW'(rx)) - CXW'(dx);
  assign cy   = $signed(CYW'(ry)) - CYW'(dy);
  assign hx   = $signed(CXW'(hr));
  assign hy   = $signed(CYW'(hr));
  assign wlim = $signed(CXW'(weff)) - hx;
  assign hlim = $signed(CYW'(heff)) - hy;

  assign int_ok = (cx >= hx) && (cx < wlim) && (cy >= hy) && (cy < hlim);

  logic [XW-1:0] cxr, nx;
  logic [YW-1:0] cyr, ny;

  always_ff @(posedge clk) begin
    if (cmd.latch_cand) begin
      cxr <= cx[XW-1:0];
      cyr <= cy[YW-1:0];
    end
  end

  always_comb begin
    nx = cxr;
    ny = cyr;
    unique case (cmd.nb)
      cbm_pkg::NB_L: nx = cxr - XW'(1);
      cbm_pkg::NB_R: nx = cxr + XW'(1);
      cbm_pkg::NB_U: ny = cyr - YW'(1);
      cbm_pkg::NB_D: ny = cyr + YW'(1);
      default: ;
    endcase
  end

  // frame store, stored at row * 2^XW + column
  logic [AW-1:0] addr;

  always_comb begin
    unique case (cmd.addr_sel)
      cbm_pkg::ADR_LOAD: addr = {by, bx};
      cbm_pkg::ADR_CAND: addr = {ny, nx};
      default:           addr = {ry, rx};
    endcase
  end

  cbm_ram #(
    .WIDTH(8),
    .DEPTH(2 ** AW)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load),
    .addr (addr),
    .wdata(pixel_value),
    .rdata(rdata)
  );

  assign sts.full     = full;
  assign sts.pass     = (rc < cbm_pkg::RADIUS_ONE) ||
                        (weff < WW'(twoh1)) || (heff < HW'(twoh1));
  assign sts.off_ok   = in_circle && int_ok;
  assign sts.off_last = (dx == hs_r) && (dy == hs_r);
  assign sts.rd_zero  = (rdata == 8'd0);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit || cmd.emit_blank;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_blank) begin
      out_pixel <= 8'd0;
      ready_res <= 1'b0;
      last      <= 1'b0;
    end else if (cmd.emit) begin
      out_pixel <= cmd.fill ? {8{cfg_mode}} : stored;
      ready_res <= 1'b1;
      last      <= rx_last && ry_last;
    end
  end

endmodule
`default_nettype wire

@@ sv/cbm_ctrl.sv @@
// controller: sequences loads, reads and the kernel walk over the frame store
`default_nettype none
module cbm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          opcode,
  input  wire cbm_pkg::sts_t sts,
  output logic               busy,
  output cbm_pkg::cmd_t      cmd
);

  cbm_pkg::state_t state, state_next;
  cbm_pkg::nb_t    k, k_next;
  logic            hit, hit_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbm_pkg::ST_IDLE;
      k     <= cbm_pkg::NB_C;
      hit   <= 1'b0;
    end else begin
      state <= state_next;
      k     <= k_next;
      hit   <= hit_next;
    end
  end

  always_comb begin
    state_next   = state;
    k_next       = k;
    hit_next     = hit;
    busy         = (state != cbm_pkg::ST_IDLE);
    cmd          = '0;
    cmd.addr_sel = cbm_pkg::ADR_READ;
    cmd.nb       = cbm_pkg::NB_C;
    unique case (state)
      cbm_pkg::ST_IDLE: begin
        if (start) begin
          if (opcode == cbm_pkg::OP_LOAD) begin
            cmd.load     = 1'b1;
            cmd.addr_sel = cbm_pkg::ADR_LOAD;
          end else if (!sts.full) begin
            cmd.emit_blank = 1'b1;
          end else begin
            hit_next   = 1'b0;
            state_next = cbm_pkg::ST_STORED;
          end
        end
      end
      cbm_pkg::ST_STORED: begin
        cmd.setup  = 1'b1;
        state_next = sts.pass ? cbm_pkg::ST_DONE : cbm_pkg::ST_OFF;
      end
      cbm_pkg::ST_OFF: begin
        if (sts.off_ok) begin
          cmd.latch_cand = 1'b1;
          state_next     = cbm_pkg::ST_ISSUE;
        end else if (sts.off_last) begin
          state_next = cbm_pkg::ST_DONE;
        end else begin
          cmd.next_off = 1'b1;
        end
      end
      cbm_pkg::ST_ISSUE: begin
        cmd.addr_sel = cbm_pkg::ADR_CAND;
        cmd.nb       = cbm_pkg::NB_C;
        k_next       = cbm_pkg::NB_C;
        state_next   = cbm_pkg::ST_CHK;
      end
      cbm_pkg::ST_CHK: begin
        // center must be set, then any zero neighbor makes a boundary
        if (k != cbm_pkg::NB_C && sts.rd_zero) begin
          hit_next   = 1'b1;
          state_next = cbm_pkg::ST_DONE;
        end else if ((k == cbm_pkg::NB_C && sts.rd_zero) || k == cbm_pkg::NB_D) begin
          if (sts.off_last) begin
            state_next = cbm_pkg::ST_DONE;
          end else begin
            cmd.next_off = 1'b1;
            state_next   = cbm_pkg::ST_OFF;
          end
        end else begin
          cmd.addr_sel = cbm_pkg::ADR_CAND;
          cmd.nb       = cbm_pkg::nb_succ(k);
          k_next       = cbm_pkg::nb_succ(k);
        end
      end
      default: begin
        cmd.emit   = 1'b1;
        cmd.fill   = hit;
        state_next = cbm_pkg::ST_IDLE;
      end
    endcase
  end

  // a check state always follows a read of the candidate
  a_chk_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == cbm_pkg::ST_CHK) |-> $past(cmd.addr_sel == cbm_pkg::ADR_CAND))
    else $error("check without a preceding candidate read");

  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (state == cbm_pkg::ST_IDLE))
    else $error("controller not idle after a result");

  a_read_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && opcode == cbm_pkg::OP_READ && sts.full))
    else $error("busy without an accepted read");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.load)
    else $error("frame store written during a read");

endmodule
`default_nettype wire

@@ sv/circular_boundary_morphology.sv @@
// top level: circular-kernel erosion and dilation of a stored mask frame
// a load item gives no result; a read before a full frame gives its result in the cycle
// after it is taken
// a read walks up to (2h+1)^2 kernel offsets, h the integer radius, through the single
// frame store port, one pixel a cycle
// reset clears control state, the frame-full flag and the positions and sets 640x480,
// radius 1.0, erode; frame store contents are undefined until loaded
`default_nettype none
module circular_boundary_morphology #(
  parameter int MAX_WIDTH  = cbm_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cbm_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = cbm_pkg::MAX_RADIUS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode,
  input  wire logic [7:0]  pixel_value,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  output logic             strobe,
  output logic [7:0]       out_pixel,
  output logic             ready_res,
  output logic             last
);

  cbm_pkg::cmd_t cmd;
  cbm_pkg::sts_t sts;

  cbm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .opcode(opcode),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  cbm_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .pixel_value(pixel_value),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .strobe     (strobe),
    .out_pixel  (out_pixel),
    .ready_res  (ready_res),
    .last       (last)
  );

endmodule
`default_nettype wire

@@ tb/tb_circular_boundary_morphology.sv @@
// testbench for the circular boundary morphology block: random frames, reads and settings
`timescale 1ns / 100ps
`default_nettype none
module tb_circular_boundary_morphology;

  typedef struct packed {
    logic [7:0] pix;
    logic       rdy;
    logic       lst;
  } mask_res_t;

  class morph_scoreboard;
    bit [7:0]    frame[int];
    int unsigned ld_pos;
    int unsigned rd_pos;
    bit          full;
    bit [10:0]   width_reg;
    bit [10:0]   height_reg;
    bit [6:0]    radius_reg;
    bit          dilate;
    mask_res_t   pending[$];
    int          errors;
    int          seen;

    function new();
      errors = 0;
      seen = 0;
      width_reg = cbm_pkg::WIDTH_RST;
      height_reg = cbm_pkg::HEIGHT_RST;
      radius_reg = cbm_pkg::RADIUS_RST;
      dilate = cbm_pkg::MODE_RST;
      restart();
    endfunction

    function void restart();
      ld_pos = 0;
      rd_pos = 0;
      full = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] d);
      case (idx)
        cbm_pkg::CFG_WIDTH: begin
          width_reg = d;
          restart();
        end
        cbm_pkg::CFG_HEIGHT: begin
          height_reg = d;
          restart();
        end
        cbm_pkg::CFG_RADIUS: radius_reg = d[6:0];
        cbm_pkg::CFG_MODE:   dilate = d[0];
        default: ;
      endcase
    endfunction

    function int frame_w();
      if (width_reg < 1) return 1;
      if (width_reg > cbm_pkg::MAX_WIDTH_DEF) return cbm_pkg::MAX_WIDTH_DEF;
      return int'(width_reg);
    endfunction

    function int frame_h();
      if (height_reg < 1) return 1;
      if (height_reg > cbm_pkg::MAX_HEIGHT_DEF) return cbm_pkg::MAX_HEIGHT_DEF;
      return int'(height_reg);
    endfunction

    function bit [7:0] px(int x, int y, int w);
      return frame[y * w + x];
    endfunction

    function bit on_boundary(int x, int y, int w, int hg, int h);
      if (x < h || x >= w - h || y < h || y >= hg - h) return 0;
      if (px(x, y, w) == 0) return 0;
      return px(x - 1, y, w) == 0 || px(x + 1, y, w) == 0 ||
             px(x, y - 1, w) == 0 || px(x, y + 1, w) == 0;
    endfunction

    function bit [7:0] morph_pixel(int x, int y, int w, int hg);
      int r;
      int h;
      bit [7:0] stored;
      stored = px(x, y, w);
      r = radius_reg;
      if (r < 16) return stored;
      if (r > cbm_pkg::MAX_RADIUS_DEF * 16 + 15) r = cbm_pkg::MAX_RADIUS_DEF * 16 + 15;
      h = r >> 4;
      if (w < 2 * h + 1 || hg < 2 * h + 1) return stored;
      for (int dy = -h; dy <= h; dy++)
        for (int dx = -h; dx <= h; dx++)
          if ((dx * dx + dy * dy) * 256 <= r * r && on_boundary(x - dx, y - dy, w, hg, h))
            return dilate ? 8'd255 : 8'd0;
      return stored;
    endfunction

    function void note_item(logic op, logic [7:0] val);
      int w;
      int hg;
      int unsigned total;
      mask_res_t e;
      w = frame_w();
      hg = frame_h();
      total = w * hg;
      if (op == cbm_pkg::OP_LOAD) begin
        if (full) restart();
        if (ld_pos < total) frame[ld_pos] = val;
        ld_pos++;
        if (ld_pos >= total) begin
          ld_pos = 0;
          rd_pos = 0;
          full = 1;
        end
        return;
      end
      if (!full || rd_pos >= total) begin
        e = '0;
      end else begin
        e.pix = morph_pixel(rd_pos % w, rd_pos / w, w, hg);
        e.rdy = 1;
        e.lst = (rd_pos == total - 1);
        rd_pos = e.lst ? 0 : rd_pos + 1;
      end
      pending.push_back(e);
    endfunction

    task flag(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [7:0] pix, logic rdy, logic lst);
      mask_res_t e;
      seen++;
      if (pending.size() == 0) begin
        flag($sformatf("unexpected result pix=%0d", pix));
        return;
      end
      e = pending.pop_front();
      if (pix !== e.pix)
        flag($sformatf("result %0d out_pixel %0d, want %0d", seen, pix, e.pix));
      if (rdy !== e.rdy)
        flag($sformatf("result %0d ready_res %0b, want %0b", seen, rdy, e.rdy));
      if (lst !== e.lst)
        flag($sformatf("result %0d last %0b, want %0b", seen, lst, e.lst));
    endtask
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic        opcode = cbm_pkg::OP_LOAD;
  logic [7:0]  pixel_value = '0;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = cbm_pkg::CFG_WIDTH;
  logic [10:0] cfg_data = '0;
  logic        strobe;
  logic [7:0]  out_pixel;
  logic        ready_res;
  logic        last;

  morph_scoreboard sb = new();
  int          items = 0;
  bit          calm = 0;

  circular_boundary_morphology dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .pixel_value(pixel_value), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .strobe(strobe), .out_pixel(out_pixel),
    .ready_res(ready_res), .last(last)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(out_pixel, ready_res, last);
  end

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task send(logic op, logic [7:0] val);
    int g;
    start <= 1;
    opcode <= op;
    pixel_value <= val;
    do @(posedge clk); while (busy);
    sb.note_item(op, val);
    items++;
    g = gap_len();
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // settle before touching registers: results drained and no read in flight
  task quiesce();
    start <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write enable stays high over back-to-back writes; setup drops it
  task write_reg(logic [1:0] idx, logic [10:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task setup(logic [10:0] w, logic [10:0] h, logic [6:0] r, logic m);
    quiesce();
    write_reg(cbm_pkg::CFG_WIDTH, w);
    write_reg(cbm_pkg::CFG_HEIGHT, h);
    write_reg(cbm_pkg::CFG_RADIUS, r);
    write_reg(cbm_pkg::CFG_MODE, m);
    cfg_we <= 0;
  endtask

  // blob frame: a nonzero rectangle with some noise, so boundaries exist
  task load_frame(int n);
    int w;
    int x0, x1, y0, y1;
    bit [7:0] v;
    w = sb.frame_w();
    x0 = $urandom_range(0, w - 1);
    x1 = $urandom_range(x0, w - 1);
    y0 = $urandom_range(0, sb.frame_h() - 1);
    y1 = $urandom_range(y0, sb.frame_h() - 1);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) v = 8'($urandom_range(0, 255));
      else if (i % w >= x0 && i % w <= x1 && i / w >= y0 && i / w <= y1)
        v = 8'($urandom_range(1, 255));
      else v = 0;
      send(cbm_pkg::OP_LOAD, v);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: read before a full frame, then a 3x3 frame with extreme bytes
    send(cbm_pkg::OP_READ, 8'hff);
    setup(11'd3, 11'd3, 7'd16, 1'b0);
    send(cbm_pkg::OP_READ, 8'h00);
    for (int i = 0; i < 9; i++)
      send(cbm_pkg::OP_LOAD, (i == 4) ? 8'hff : ((i % 2) ? 8'h01 : 8'h00));
    repeat (10) send(cbm_pkg::OP_READ, 8'h00);
    // load after a full frame restarts it
    send(cbm_pkg::OP_LOAD, 8'h80);
    send(cbm_pkg::OP_READ, 8'h00);
    // radius below 1.0, then the largest radius on a frame too small for it
    setup(11'd5, 11'd5, 7'd15, 1'b1);
    load_frame(25);
    repeat (3) send(cbm_pkg::OP_READ, 8'h00);
    setup(11'd5, 11'd5, 7'd127, 1'b1);
    load_frame(25);
    repeat (3) send(cbm_pkg::OP_READ, 8'h00);
    // saturated width: a short partial frame still reads as not ready
    setup(11'd2047, 11'd1, 7'd16, 1'b0);
    load_frame(40);
    repeat (2) send(cbm_pkg::OP_READ, 8'h00);
    // zero geometry
    setup(11'd0, 11'd0, 7'd0, 1'b0);
    send(cbm_pkg::OP_LOAD, 8'h7f);
    repeat (2) send(cbm_pkg::OP_READ, 8'h00);

    while (items < 500) begin
      int w, h, reads;
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 20);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 18);
      calm = ($urandom_range(0, 3) == 0);
      setup(11'(w), 11'(h), 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0) begin
        // broken sequence: partial frame and early reads
        load_frame($urandom_range(0, w * h - 1));
        repeat ($urandom_range(1, 3)) send(cbm_pkg::OP_READ, 8'($urandom_range(0, 255)));
      end else begin
        load_frame(w * h);
        reads = $urandom_range(1, 12);
        repeat (reads) send(cbm_pkg::OP_READ, 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0) begin
          load_frame(w * h);
          repeat (3) send(cbm_pkg::OP_READ, 8'h00);
        end
      end
    end

    quiesce();
    repeat (1700) @(posedge clk);
    if (sb.pending.size() != 0)
      sb.flag($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
sv/cbm_pkg.sv
sv/cbm_ram.sv
sv/cbm_dp.sv
sv/cbm_ctrl.sv
sv/circular_boundary_morphology.sv
tb/tb_circular_boundary_morphology.sv
